// ----- hw/rtl/quantizer_spec_table_builder_core_assert.svh -----
// ----------------------------------------------------------------------------
// quantizer spec table builder assertion macros
// concurrent checks clocked on clk_i and held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef QUANTIZER_SPEC_TABLE_BUILDER_CORE_ASSERT_SVH
`define QUANTIZER_SPEC_TABLE_BUILDER_CORE_ASSERT_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define QSTB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qstb assertion failed");

// antecedent holds in a cycle, consequent must hold in the next cycle
`define QSTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qstb assertion failed");

`endif

// ----- hw/rtl/qstb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qstb_pkg
// shared constants, codes and types of the quantizer spec table builder
// ----------------------------------------------------------------------------
package qstb_pkg;

  localparam int TableEntries = 256;
  localparam int IdxW         = $clog2(TableEntries);
  // fill index and limit hold up to TableEntries + 1
  localparam int CntW         = $clog2(TableEntries + 2);
  localparam int LimW         = CntW + 4;
  localparam int CmpW         = (CntW > 8) ? CntW : 8;
  localparam int Radix        = 10;

  localparam int QueueDepth   = 2;
  localparam int QPtrW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW        = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharColon = 8'h3A;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FEED  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] table_value;
  } out_item_t;

  // one classified request from the parser to the table engine
  typedef struct packed {
    cmd_kind_e           kind;
    status_e             status;
    logic [7:0]          value;
    logic [CntW-1:0]     lo;
    logic [CntW-1:0]     hi;
    logic [7:0]          read_index;
  } cmd_t;

  typedef struct packed {
    logic            idle;
    logic            fill_busy;
    logic [CntW-1:0] filled;
    logic [CntW-1:0] ptr;
  } back_stat_t;

endpackage

// ----- hw/rtl/qstb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qstb_front
// spec parser: takes one request a cycle while the command queue is not full, updates
// the parse state and hands a classified command to the table engine queue
// ----------------------------------------------------------------------------
module qstb_front
  import qstb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  input  logic            q_full_i,
  output logic            push_o,
  output cmd_t            cmd_o,
  output logic [CntW-1:0] fill_index_o
);

  typedef enum logic [3:0] {
    PH_VALUE = 4'b0001,
    PH_COLON = 4'b0010,
    PH_LIMIT = 4'b0100,
    PH_COMMA = 4'b1000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            skip_q, skip_d;
  logic [7:0]      value_q, value_d;
  logic [CntW-1:0] limit_q, limit_d;
  logic [CntW-1:0] fill_q, fill_d;
  status_e         outcome_q, outcome_d;

  logic [7:0]      c;
  logic            c_blank, c_digit;
  logic [3:0]      digit;
  logic [LimW-1:0] lim_next;
  logic [7:0]      val_next;

  assign in_ready_o   = !q_full_i;
  assign push_o       = in_valid_i && in_ready_o;
  assign fill_index_o = fill_q;

  assign c        = in_item_i.character;
  assign c_blank  = (c == CharSpace) || (c >= CharTab && c <= CharCr);
  assign c_digit  = (c >= CharZero) && (c <= CharNine);
  assign digit    = 4'(c - CharZero);
  assign val_next = value_q * 8'(Radix) + 8'(digit);
  assign lim_next = LimW'(limit_q) * LimW'(Radix) + LimW'(digit);

  always_comb begin
    phase_e ph;
    logic   done;
    ph        = phase_q;
    done      = 1'b0;
    phase_d   = phase_q;
    skip_d    = skip_q;
    value_d   = value_q;
    limit_d   = limit_q;
    fill_d    = fill_q;
    outcome_d = outcome_q;
    cmd_o            = '0;
    cmd_o.kind       = CMD_NONE;
    cmd_o.read_index = in_item_i.read_index;
    cmd_o.value      = value_q;
    cmd_o.lo         = fill_q;
    cmd_o.hi         = fill_q;

    unique case (op_e'(in_item_i.operation))
      OP_START: begin
        phase_d    = PH_VALUE;
        skip_d     = 1'b1;
        value_d    = '0;
        limit_d    = '0;
        fill_d     = '0;
        outcome_d  = ST_BUSY;
        cmd_o.kind = CMD_CLEAR;
      end
      OP_FEED: begin
        if (outcome_q == ST_BUSY) begin
          if (c == CharNul) begin
            outcome_d = ST_FAIL;
          end else if (skip_q && c_blank) begin
            skip_d = 1'b1;
          end else begin
            skip_d = 1'b0;
            if (ph == PH_VALUE) begin
              if (c_digit) begin
                value_d = val_next;
                done    = 1'b1;
              end else if (c_blank) begin
                phase_d = PH_COLON;
                skip_d  = 1'b1;
                done    = 1'b1;
              end else begin
                ph = PH_COLON;
              end
            end
            if (!done && ph == PH_COLON) begin
              done = 1'b1;
              if (c != CharColon) begin
                outcome_d = ST_FAIL;
              end else begin
                skip_d  = 1'b1;
                phase_d = PH_LIMIT;
              end
            end
            if (!done && ph == PH_LIMIT) begin
              if (c_digit) begin
                // saturate one past the table size
                if (lim_next > LimW'(TableEntries + 1)) begin
                  limit_d = CntW'(TableEntries + 1);
                end else begin
                  limit_d = CntW'(lim_next);
                end
                done = 1'b1;
              end else if (c_blank) begin
                phase_d = PH_COMMA;
                skip_d  = 1'b1;
                done    = 1'b1;
              end else if (c == CharDash && limit_q == '0) begin
                // fill the rest and finish
                cmd_o.kind = CMD_FILL;
                cmd_o.hi   = CntW'(TableEntries);
                fill_d     = CntW'(TableEntries);
                outcome_d  = ST_OK;
                done       = 1'b1;
              end else begin
                ph = PH_COMMA;
              end
            end
            if (!done && ph == PH_COMMA) begin
              if (c != CharComma) begin
                outcome_d = ST_FAIL;
              end else begin
                skip_d  = 1'b1;
                phase_d = PH_VALUE;
                if (fill_q > limit_q || limit_q > CntW'(TableEntries)) begin
                  outcome_d = ST_FAIL;
                end else begin
                  cmd_o.kind = CMD_FILL;
                  cmd_o.hi   = limit_q;
                  fill_d     = limit_q;
                  limit_d    = '0;
                  value_d    = '0;
                end
              end
            end
          end
        end
      end
      OP_READ: begin
        cmd_o.kind = CMD_READ;
      end
      default: begin
        cmd_o.kind = CMD_NONE;
      end
    endcase
    cmd_o.status = outcome_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VALUE;
      skip_q    <= 1'b1;
      value_q   <= '0;
      limit_q   <= '0;
      fill_q    <= '0;
      outcome_q <= ST_BUSY;
    end else if (push_o) begin
      phase_q   <= phase_d;
      skip_q    <= skip_d;
      value_q   <= value_d;
      limit_q   <= limit_d;
      fill_q    <= fill_d;
      outcome_q <= outcome_d;
    end
  end

endmodule

// ----- hw/rtl/qstb_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qstb_fifo
// short command queue between the parser and the table engine
// ----------------------------------------------------------------------------
module qstb_fifo
  import qstb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t             entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
    if (p == QPtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/qstb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qstb_back
// table engine: owns the table memory, fills one entry a cycle, serves
// reads and holds each result in an output register until taken
// ----------------------------------------------------------------------------
module qstb_back
  import qstb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o,
  output back_stat_t stat_o
);

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_FILL = 4'b0010,
    BK_READ = 4'b0100,
    BK_EMIT = 4'b1000
  } back_state_e;

  back_state_e     state_q, state_d;
  logic [7:0]      mem_q [TableEntries];
  logic [7:0]      rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;

  // entries at and above filled_q read as zero
  logic [CntW-1:0] filled_q, filled_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [CntW-1:0] ptr_inc;
  logic [7:0]      value_q, value_d;
  status_e         status_q, status_d;
  logic            hit_q, hit_d;
  out_item_t       out_q, out_d;

  assign rd_addr     = IdxW'(q_head_i.read_index);
  assign ptr_inc     = ptr_q + 1'b1;
  assign out_valid_o = (state_q == BK_EMIT);
  assign out_item_o  = out_q;

  assign stat_o.idle      = (state_q == BK_IDLE);
  assign stat_o.fill_busy = (state_q == BK_FILL);
  assign stat_o.filled    = filled_q;
  assign stat_o.ptr       = ptr_q;

  always_comb begin
    state_d  = state_q;
    filled_d = filled_q;
    ptr_d    = ptr_q;
    hi_d     = hi_q;
    value_d  = value_q;
    status_d = status_q;
    hit_d    = hit_q;
    out_d    = out_q;
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o  = 1'b1;
          status_d = q_head_i.status;
          out_d    = '{status: q_head_i.status, table_value: 8'h00};
          case (q_head_i.kind)
            CMD_CLEAR: begin
              filled_d = '0;
              state_d  = BK_EMIT;
            end
            CMD_FILL: begin
              value_d = q_head_i.value;
              ptr_d   = q_head_i.lo;
              hi_d    = q_head_i.hi;
              state_d = (q_head_i.lo < q_head_i.hi) ? BK_FILL : BK_EMIT;
            end
            CMD_READ: begin
              hit_d   = CmpW'(q_head_i.read_index) < CmpW'(filled_q);
              state_d = BK_READ;
            end
            default: begin
              state_d = BK_EMIT;
            end
          endcase
        end
      end
      BK_FILL: begin
        mem_we   = 1'b1;
        ptr_d    = ptr_inc;
        filled_d = ptr_inc;
        if (ptr_inc == hi_q) begin
          state_d = BK_EMIT;
        end
      end
      BK_READ: begin
        out_d   = '{status: status_q, table_value: hit_q ? rd_data_q : 8'h00};
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[ptr_q[IdxW-1:0]] <= value_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    hi_q     <= hi_d;
    value_q  <= value_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      filled_q <= '0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
    end
  end

endmodule

// ----- hw/rtl/quantizer_spec_table_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantizer_spec_table_builder_core
// parses a value:limit,...,value:- spec one character per request and
// builds a byte table that read requests return
// ----------------------------------------------------------------------------
// results: a read passes through a registered memory read before its result is valid,
//   and a pair that fills the table writes all of its entries first
// throughput: the table engine finishes one request before it takes the next and fills
//   one entry per cycle, set by the table engine's single memory write port
// reset: parser as after a start, whole table reads zero; no clearing pass
module quantizer_spec_table_builder_core
  import qstb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  `include "quantizer_spec_table_builder_core_assert.svh"

  logic            push, pop, q_empty, q_full;
  cmd_t            push_cmd, head_cmd;
  logic [CntW-1:0] front_fill;
  back_stat_t      back_stat;
  logic            fill_busy;
  logic [CntW-1:0] fill_ptr;

  assign fill_busy = back_stat.fill_busy;
  assign fill_ptr  = back_stat.ptr;

  qstb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .fill_index_o (front_fill)
  );

  qstb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  qstb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .stat_o      (back_stat)
  );

  // a taken result is never shown twice
  `QSTB_ASSERT_NEXT(a_single_emit, out_valid_o && out_ready_i, !out_valid_o)

  // when all work has drained the engine's filled mark matches the parser
  `QSTB_ASSERT_SAME(a_fill_sync, q_empty && back_stat.idle, back_stat.filled == front_fill)

  // a fill sweep advances one entry every cycle
  `QSTB_ASSERT_SAME(a_fill_step, fill_busy && $past(fill_busy), fill_ptr == CntW'($past(fill_ptr) + 1'b1))

endmodule

// ----- dv/quantizer_spec_table_builder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantizer_spec_table_builder_core_tb
// sends start, feed and read requests and checks every result against an
// in-bench model of the spec parser and its byte table; covers well-formed
// specs with random spacing, broken specs, random noise and a long output stall
// ----------------------------------------------------------------------------
module quantizer_spec_table_builder_core_tb;
  import qstb_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 300;
  localparam int DrainWait  = TableEntries + 40;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef enum logic [1:0] {
    PH_VALUE = 2'd0,
    PH_COLON = 2'd1,
    PH_LIMIT = 2'd2,
    PH_COMMA = 2'd3
  } phase_e;

  typedef enum int {
    FLAW_NONE,
    FLAW_BYTE,
    FLAW_NUL,
    FLAW_BIG_LIMIT,
    FLAW_LOW_LIMIT,
    FLAW_NO_END
  } flaw_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  quantizer_spec_table_builder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // parser and table model
  logic [7:0]  table_m [TableEntries];
  phase_e      phase_m;
  bit          skip_m;
  logic [7:0]  value_m;
  int unsigned limit_m;
  int unsigned fill_m;
  status_e     outcome_m;

  out_item_t expected_results[$];

  int  error_count     = 0;
  int  requests_sent   = 0;
  int  results_checked = 0;
  int  specs_done      = 0;
  int  specs_ok        = 0;
  int  specs_rejected  = 0;
  int  burst_left      = 0;
  int  gap_max         = 3;
  int  stall_pct       = 20;
  bit  hold_req        = 1'b0;

  function automatic bit is_blank(logic [7:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic void model_clear();
    foreach (table_m[k]) table_m[k] = 8'h00;
    phase_m   = PH_VALUE;
    skip_m    = 1'b1;
    value_m   = 8'h00;
    limit_m   = 0;
    fill_m    = 0;
    outcome_m = ST_BUSY;
  endfunction

  function automatic void model_fill(int unsigned stop);
    for (int unsigned k = fill_m; k < stop && k < TableEntries; k++) table_m[k] = value_m;
  endfunction

  function automatic void model_feed(logic [7:0] c);
    if (outcome_m != ST_BUSY) return;
    if (c == CharNul) begin
      outcome_m = ST_FAIL;
      return;
    end
    if (skip_m) begin
      if (is_blank(c)) return;
      skip_m = 1'b0;
    end
    if (phase_m == PH_VALUE) begin
      if (is_digit(c)) begin
        value_m = 8'(int'(value_m) * Radix + int'(c - CharZero));
        return;
      end
      if (is_blank(c)) begin
        phase_m = PH_COLON;
        skip_m  = 1'b1;
        return;
      end
      phase_m = PH_COLON;
    end
    if (phase_m == PH_COLON) begin
      if (c != CharColon) begin
        outcome_m = ST_FAIL;
        return;
      end
      skip_m  = 1'b1;
      phase_m = PH_LIMIT;
      return;
    end
    if (phase_m == PH_LIMIT) begin
      if (is_digit(c)) begin
        limit_m = limit_m * Radix + int'(c - CharZero);
        // saturates one above the table size
        if (limit_m > TableEntries + 1) limit_m = TableEntries + 1;
        return;
      end
      if (is_blank(c)) begin
        phase_m = PH_COMMA;
        skip_m  = 1'b1;
        return;
      end
      if (c == CharDash && limit_m == 0) begin
        model_fill(TableEntries);
        fill_m    = TableEntries;
        outcome_m = ST_OK;
        return;
      end
      phase_m = PH_COMMA;
    end
    if (c != CharComma) begin
      outcome_m = ST_FAIL;
      return;
    end
    skip_m  = 1'b1;
    phase_m = PH_VALUE;
    if (fill_m > limit_m || limit_m > TableEntries) begin
      outcome_m = ST_FAIL;
      return;
    end
    model_fill(limit_m);
    fill_m  = limit_m;
    limit_m = 0;
    value_m = 8'h00;
  endfunction

  function automatic out_item_t model_step(in_item_t it);
    out_item_t res;
    logic [7:0] val;
    val = 8'h00;
    case (it.operation)
      OP_START: model_clear();
      OP_FEED:  model_feed(it.character);
      OP_READ: begin
        if (int'(it.read_index) < TableEntries) val = table_m[it.read_index];
      end
      default: ;
    endcase
    res.status      = outcome_m;
    res.table_value = val;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_checked, what, got,
             want);
    error_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending, status", out_item_o.status, 8'h00);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch("status", out_item_o.status, want.status);
        if (out_item_o.table_value !== want.table_value)
          report_mismatch("table_value", out_item_o.table_value, want.table_value);
      end
    end
  end

  // receiver: random stall streaks, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int streak;
    hold_left = 0;
    streak    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (streak > 0) begin
        streak--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        streak = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CycleLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // called at a rising edge; returns at the edge that accepted the request
  task automatic send_request(logic [1:0] op, logic [7:0] ch, logic [7:0] idx);
    in_item_t it;
    int gap;
    it.operation  = op;
    it.character  = ch;
    it.read_index = idx;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap_max != 0 && $urandom_range(0, 19) == 0) gap = gap_max * 6;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_results.push_back(model_step(it));
    requests_sent++;
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(OP_FEED, s[i], 8'($urandom));
  endtask

  function automatic void add_blanks(ref logic [7:0] txt[$]);
    int pick;
    if ($urandom_range(0, 2) != 0) return;
    repeat ($urandom_range(1, 2)) begin
      pick = $urandom_range(0, 5);
      txt.push_back((pick == 0) ? CharSpace : 8'(CharTab + pick - 1));
    end
  endfunction

  function automatic void add_number(ref logic [7:0] txt[$], input int unsigned n);
    string s;
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) txt.push_back(CharZero);
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic int unsigned pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 9);
      1:       return $urandom_range(0, 255);
      2:       return $urandom_range(0, 999);
      default: return ($urandom_range(0, 1) != 0) ? 255 : 256;
    endcase
  endfunction

  function automatic void build_spec(ref logic [7:0] txt[$], input flaw_e flaw);
    int unsigned npairs, fill_at, lim, span, bad_at, pos;
    txt.delete();
    fill_at = 0;
    npairs  = $urandom_range(0, 5);
    if (npairs < 2 && (flaw == FLAW_BIG_LIMIT || flaw == FLAW_LOW_LIMIT)) npairs = 2;
    bad_at = (flaw == FLAW_LOW_LIMIT) ? npairs - 1 : $urandom_range(0, npairs);
    add_blanks(txt);
    for (int unsigned p = 0; p < npairs; p++) begin
      span = TableEntries - fill_at;
      lim  = fill_at + $urandom_range(0, (span > 90) ? 90 : span);
      if ($urandom_range(0, 9) == 0) lim = TableEntries;
      if (p == bad_at && flaw == FLAW_BIG_LIMIT) lim = $urandom_range(TableEntries + 1, 99999);
      if (p == bad_at && flaw == FLAW_LOW_LIMIT && fill_at > 0)
        lim = $urandom_range(0, fill_at - 1);
      // an empty value reads as zero
      if ($urandom_range(0, 9) != 0) add_number(txt, pick_value());
      add_blanks(txt);
      txt.push_back(CharColon);
      add_blanks(txt);
      add_number(txt, lim);
      add_blanks(txt);
      txt.push_back(CharComma);
      add_blanks(txt);
      if (lim <= TableEntries) fill_at = lim;
    end
    add_number(txt, pick_value());
    add_blanks(txt);
    txt.push_back(CharColon);
    add_blanks(txt);
    // zero digits right before the dash still leave the limit at zero
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) txt.push_back(CharZero);
    txt.push_back(CharDash);
    if (flaw == FLAW_NO_END) begin
      void'(txt.pop_back());
    end else if (flaw == FLAW_BYTE || flaw == FLAW_NUL) begin
      pos = $urandom_range(0, txt.size() - 1);
      txt[pos] = (flaw == FLAW_NUL) ? CharNul : 8'($urandom_range(0, 255));
    end
  endfunction

  task automatic run_spec(flaw_e flaw, int read_pct);
    logic [7:0] txt[$];
    build_spec(txt, flaw);
    send_request(OP_START, 8'($urandom), 8'($urandom));
    foreach (txt[i]) begin
      if ($urandom_range(1, 100) <= read_pct) send_request(OP_READ, 8'($urandom), 8'($urandom));
      send_request(OP_FEED, txt[i], 8'($urandom));
    end
    // trailing feeds are ignored once the spec has ended
    repeat ($urandom_range(2, 6)) begin
      if ($urandom_range(0, 3) == 0) send_request(OP_FEED, 8'($urandom), 8'($urandom));
      else send_request(OP_READ, 8'($urandom), 8'($urandom));
    end
    specs_done++;
    if (outcome_m == ST_OK) specs_ok++;
    else if (outcome_m == ST_FAIL) specs_rejected++;
  endtask

  task automatic test_directed_cases();
    send_request(OP_READ, 8'h00, 8'h00);
    send_request(OpUnused, 8'hFF, 8'hFF);
    send_request(OP_START, 8'h00, 8'h00);
    // value wraps modulo 256, dash after zero digits fills the whole table
    feed_text("\t999:00-");
    send_request(OP_FEED, 8'hFF, 8'h00);
    send_request(OP_READ, 8'h00, 8'hFF);
    send_request(OP_START, 8'hFF, 8'h00);
    // second limit lies below the fill index
    feed_text("9:2 ,8:1,");
    send_request(OP_READ, 8'h00, 8'h01);
    send_request(OP_READ, 8'h00, 8'h02);
  endtask

  task automatic test_wellformed_specs(int target);
    while (requests_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        gap_max   = 0;
        stall_pct = 0;
      end else begin
        gap_max   = $urandom_range(1, 6);
        stall_pct = $urandom_range(10, 50);
      end
      run_spec(FLAW_NONE, $urandom_range(0, 30));
    end
  endtask

  task automatic test_output_hold_off();
    gap_max   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    run_spec(FLAW_NONE, 30);
    gap_max   = 3;
    stall_pct = 20;
  endtask

  task automatic test_broken_specs(int target);
    while (requests_sent < target) begin
      gap_max   = $urandom_range(0, 4);
      stall_pct = $urandom_range(0, 40);
      run_spec(flaw_e'($urandom_range(FLAW_BYTE, FLAW_NO_END)), $urandom_range(0, 20));
    end
  endtask

  task automatic test_random_noise(int count);
    logic [1:0] op;
    logic [7:0] ch;
    int pick;
    gap_max   = 2;
    stall_pct = 25;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      op = (pick < 10) ? OP_START : (pick < 65) ? OP_FEED : (pick < 95) ? OP_READ : OpUnused;
      case ($urandom_range(0, 3))
        0:       ch = 8'($urandom_range(CharZero, CharNine));
        1: begin
          pick = $urandom_range(0, 2);
          ch = (pick == 0) ? CharColon : (pick == 1) ? CharComma : CharDash;
        end
        2:       ch = ($urandom_range(0, 1) != 0) ? CharSpace : 8'($urandom_range(CharTab, CharCr));
        default: ch = 8'($urandom);
      endcase
      send_request(op, ch, 8'($urandom));
    end
  endtask

  initial begin
    model_clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_wellformed_specs(requests_sent + 900);
    test_output_hold_off();
    test_broken_specs(requests_sent + 380);
    test_random_noise(120);

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d specs: %0d built the table, %0d rejected, %0d left open",
             specs_done, specs_ok, specs_rejected, specs_done - specs_ok - specs_rejected);
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_checked, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/qstb_pkg.sv
hw/rtl/qstb_front.sv
hw/rtl/qstb_fifo.sv
hw/rtl/qstb_back.sv
hw/rtl/quantizer_spec_table_builder_core.sv
dv/quantizer_spec_table_builder_core_tb.sv
